FILE: src/motor_run_sequencer_top_defines.svh
// Assertion macros shared by the motor run sequencer checkers.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef MOTOR_RUN_SEQUENCER_TOP_DEFINES_SVH
`define MOTOR_RUN_SEQUENCER_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define MRS_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define MRS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mrs_pkg.sv
// Types, codes and constants of the motor run sequencer.
// No dependencies; every other file but the macros header refers to it by scoped names.
package mrs_pkg;

    localparam int unsigned REQ_W      = 3;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned LEVEL_W    = 10;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned DIR_W      = 2;
    localparam int unsigned SETP_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'd1000;
    localparam int unsigned STEP_SHIFT = 4;

    // level * 255 / 1000 as one multiply by 255 * ceil(2^28 / 1000), then a shift
    localparam int unsigned DUTY_SHIFT = 28;
    localparam int unsigned DUTY_MUL_W = 27;
    localparam int unsigned DUTY_PROD_W = LEVEL_W + DUTY_MUL_W;
    localparam logic [DUTY_MUL_W-1:0] DUTY_MUL = 27'd68451180;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 3'd0,
        REQ_START = 3'd1,
        REQ_STOP  = 3'd2,
        REQ_ESTOP = 3'd3,
        REQ_APPLY = 3'd4
    } req_type_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_DEFAULT = 2'd0,
        MODE_SPEED   = 2'd1,
        MODE_TIMED   = 2'd2,
        MODE_INVALID = 2'd3
    } mode_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_COAST = 2'd0,
        DIR_FWD   = 2'd1,
        DIR_REV   = 2'd2
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 2'd0,
        CFG_LEVEL   = 2'd1,
        CFG_TARGET  = 2'd2,
        CFG_REVERSE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SETP_W-1:0] level;
        logic [TICK_W-1:0] target;
        logic              reverse;
    } cfg_t;

    typedef struct packed {
        logic               run_flag;
        logic               active_timed;
        logic [TICK_W-1:0]  active_target;
        logic               active_reverse;
        logic [POS_W-1:0]   pos;
        logic [LEVEL_W-1:0] level;
        logic [TICK_W-1:0]  ticks;
        logic [DUTY_W-1:0]  duty;
        logic [DIR_W-1:0]   dir;
        logic               stby;
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [LEVEL_W-1:0] drive_level;
        logic [TICK_W-1:0]  elapsed;
        logic [DUTY_W-1:0]  pwm_duty;
        logic [DIR_W-1:0]   bridge_dir;
        logic               driver_enable;
        logic               running;
        logic               accepted;
        logic               target_done;
        logic               published;
    } result_t;

endpackage

FILE: src/mrs_req_if.sv
// Request channel of the motor run sequencer: valid, ready and the event fields.
// Depends on mrs_pkg for the field widths.
interface mrs_req_if;
    logic                      valid;
    logic                      ready;
    logic [mrs_pkg::REQ_W-1:0] req_type;
    logic                      sys_running;
    logic                      sys_estopped;

    modport source (output valid, output req_type, output sys_running,
                    output sys_estopped, input ready);
    modport sink   (input valid, input req_type, input sys_running,
                    input sys_estopped, output ready);
endinterface

FILE: src/mrs_res_if.sv
// Result channel of the motor run sequencer: valid, ready and the feedback fields.
// Depends on mrs_pkg for the field widths.
interface mrs_res_if;
    logic                        valid;
    logic                        ready;
    logic [mrs_pkg::POS_W-1:0]   position;
    logic [mrs_pkg::LEVEL_W-1:0] drive_level;
    logic [mrs_pkg::TICK_W-1:0]  elapsed;
    logic [mrs_pkg::DUTY_W-1:0]  pwm_duty;
    logic [mrs_pkg::DIR_W-1:0]   bridge_dir;
    logic                        driver_enable;
    logic                        running;
    logic                        accepted;
    logic                        target_done;
    logic                        published;

    modport source (output valid, output position, output drive_level, output elapsed,
                    output pwm_duty, output bridge_dir, output driver_enable,
                    output running, output accepted, output target_done,
                    output published, input ready);
    modport sink   (input valid, input position, input drive_level, input elapsed,
                    input pwm_duty, input bridge_dir, input driver_enable,
                    input running, input accepted, input target_done,
                    input published, output ready);
endinterface

FILE: src/mrs_core.sv
// Next-state and feedback logic for one request of the motor run sequencer.
// Purely combinational; depends on mrs_pkg.
module mrs_core (
    input  mrs_pkg::state_t            state,
    input  mrs_pkg::cfg_t              cfg,
    input  logic [mrs_pkg::REQ_W-1:0]  req_type,
    input  logic                       sys_running,
    input  logic                       sys_estopped,
    output mrs_pkg::state_t            state_next,
    output mrs_pkg::result_t           result
);

    localparam int unsigned STEP_W = mrs_pkg::LEVEL_W - mrs_pkg::STEP_SHIFT;

    logic                               mode_invalid;
    logic                               apply_timed;
    logic                               apply_ok;
    logic [mrs_pkg::LEVEL_W-1:0]        level_clamped;
    logic [mrs_pkg::DUTY_PROD_W-1:0]    duty_prod;
    logic [mrs_pkg::DUTY_W-1:0]         start_duty;
    logic [STEP_W-1:0]                  step_raw;
    logic [STEP_W-1:0]                  step;
    logic [mrs_pkg::POS_W-1:0]          step_wide;
    logic [mrs_pkg::POS_W-1:0]          pos_fwd;
    logic [mrs_pkg::POS_W-1:0]          pos_rev;
    logic [mrs_pkg::TICK_W-1:0]         ticks_inc;
    logic                               tick_done;
    logic                               accepted;
    logic                               done;
    logic                               published;
    mrs_pkg::state_t                    applied;

    function automatic mrs_pkg::state_t stop_run(mrs_pkg::state_t s);
        mrs_pkg::state_t r;
        r          = s;
        r.run_flag = 1'b0;
        r.stby     = 1'b1;
        r.duty     = '0;
        r.dir      = mrs_pkg::DIR_COAST;
        r.level    = '0;
        return r;
    endfunction

    // Config apply, shared by run start and apply requests
    assign mode_invalid  = (cfg.mode == mrs_pkg::MODE_INVALID);
    assign apply_timed   = (cfg.mode == mrs_pkg::MODE_TIMED);
    assign apply_ok      = !mode_invalid && !(apply_timed && (cfg.target == '0));
    assign level_clamped = (cfg.level > mrs_pkg::SETP_W'(mrs_pkg::LEVEL_MAX))
                         ? mrs_pkg::LEVEL_MAX : cfg.level[mrs_pkg::LEVEL_W-1:0];
    assign duty_prod     = mrs_pkg::DUTY_PROD_W'(level_clamped)
                         * mrs_pkg::DUTY_PROD_W'(mrs_pkg::DUTY_MUL);
    assign start_duty    = duty_prod[mrs_pkg::DUTY_SHIFT +: mrs_pkg::DUTY_W];

    always_comb
    begin
        applied = state;
        if (!mode_invalid)
        begin
            applied.active_timed   = apply_timed;
            applied.active_target  = cfg.target;
            applied.active_reverse = cfg.reverse;
            if (apply_ok)
            begin
                applied.ticks = '0;
                applied.level = level_clamped;
            end
        end
    end

    // Tick arithmetic; a zero step leaves either direction unchanged
    assign step_raw  = state.level[mrs_pkg::LEVEL_W-1:mrs_pkg::STEP_SHIFT];
    assign step      = ((state.level != '0) && (step_raw == '0)) ? STEP_W'(1) : step_raw;
    assign step_wide = mrs_pkg::POS_W'(step);
    assign pos_fwd   = state.pos + step_wide;
    assign pos_rev   = (state.pos > step_wide) ? (state.pos - step_wide) : '0;
    assign ticks_inc = state.ticks + mrs_pkg::TICK_W'(1);
    assign tick_done = state.active_timed && (ticks_inc >= state.active_target);

    always_comb
    begin
        state_next = state;
        accepted   = 1'b0;
        done       = 1'b0;
        published  = 1'b0;
        unique case (req_type)
            mrs_pkg::REQ_TICK:
            begin
                if (state.run_flag)
                begin
                    published = 1'b1;
                    if (!sys_running || sys_estopped)
                    begin
                        state_next = stop_run(state);
                    end
                    else
                    begin
                        state_next.ticks = ticks_inc;
                        state_next.pos   = state.active_reverse ? pos_rev : pos_fwd;
                        if (tick_done)
                        begin
                            state_next = stop_run(state_next);
                            done       = 1'b1;
                        end
                    end
                end
            end
            mrs_pkg::REQ_START:
            begin
                published = 1'b1;
                if (!apply_ok)
                begin
                    state_next = stop_run(applied);
                end
                else
                begin
                    state_next          = applied;
                    state_next.run_flag = 1'b1;
                    state_next.stby     = 1'b1;
                    state_next.dir      = applied.active_reverse ? mrs_pkg::DIR_REV
                                                                 : mrs_pkg::DIR_FWD;
                    state_next.duty     = start_duty;
                    accepted            = 1'b1;
                end
            end
            mrs_pkg::REQ_STOP:
            begin
                published  = 1'b1;
                state_next = stop_run(state);
            end
            mrs_pkg::REQ_ESTOP:
            begin
                published           = 1'b1;
                state_next.run_flag = 1'b0;
                state_next.level    = '0;
                state_next.duty     = '0;
                state_next.dir      = mrs_pkg::DIR_COAST;
                state_next.stby     = 1'b0;
            end
            mrs_pkg::REQ_APPLY:
            begin
                published  = 1'b1;
                state_next = applied;
                accepted   = apply_ok;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    always_comb
    begin
        result.position      = state_next.pos;
        result.drive_level   = state_next.level;
        result.elapsed       = state_next.ticks;
        result.pwm_duty      = state_next.duty;
        result.bridge_dir    = state_next.dir;
        result.driver_enable = state_next.stby;
        result.running       = state_next.run_flag;
        result.accepted      = accepted;
        result.target_done   = done;
        result.published     = published;
    end

endmodule

FILE: src/mrs_out_buf.sv
// Output register with a skid stage for the motor run sequencer result channel.
// Depends on mrs_pkg and mrs_res_if.
module mrs_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mrs_pkg::result_t  push_data,
    output logic              can_push,
    mrs_res_if.source         res
);

    mrs_pkg::result_t main_reg;
    mrs_pkg::result_t skid_reg;
    logic             main_valid_reg;
    logic             skid_valid_reg;
    logic             pop;

    assign pop      = main_valid_reg && res.ready;
    assign can_push = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    // Payload: advance skid into main on a pop, otherwise land the new result
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
        else if (push && (pop || !main_valid_reg))
        begin
            main_reg <= push_data;
        end
        if (push && main_valid_reg && !pop)
        begin
            skid_reg <= push_data;
        end
    end

    assign res.valid         = main_valid_reg;
    assign res.position      = main_reg.position;
    assign res.drive_level   = main_reg.drive_level;
    assign res.elapsed       = main_reg.elapsed;
    assign res.pwm_duty      = main_reg.pwm_duty;
    assign res.bridge_dir    = main_reg.bridge_dir;
    assign res.driver_enable = main_reg.driver_enable;
    assign res.running       = main_reg.running;
    assign res.accepted      = main_reg.accepted;
    assign res.target_done   = main_reg.target_done;
    assign res.published     = main_reg.published;

endmodule

FILE: src/motor_run_sequencer_top.sv
// Motor run sequencer top level; uses mrs_pkg, mrs_req_if, mrs_res_if, mrs_core, mrs_out_buf.
// Each accepted result is registered in the output register, or in the skid while one waits.
// Throughput: one request per cycle; the two-entry output stage (register plus skid)
// keeps requests flowing while one result waits, ready drops only when both are full.
// Reset (rst_n low, asynchronous): config to speed mode with zero level, target and
// direction; run state idle, coasting with the driver enabled; output stage empty.
module motor_run_sequencer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    mrs_req_if.sink                          req,
    mrs_res_if.source                        res,
    input  logic                             cfg_we,
    input  logic [mrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mrs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // Configuration registers, sampled by run start and apply requests
    mrs_pkg::cfg_t    cfg_reg;

    // Run state carried from one request to the next
    mrs_pkg::state_t  state_reg;
    mrs_pkg::state_t  state_next;

    mrs_pkg::result_t result;
    logic             can_push;
    logic             accept;

    assign req.ready = can_push;
    assign accept    = req.valid && req.ready;

    // Register writes: take the low bits of the data for each register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode    <= mrs_pkg::MODE_SPEED;
            cfg_reg.level   <= '0;
            cfg_reg.target  <= '0;
            cfg_reg.reverse <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mrs_pkg::CFG_MODE:    cfg_reg.mode    <= cfg_wdata[mrs_pkg::MODE_W-1:0];
                mrs_pkg::CFG_LEVEL:   cfg_reg.level   <= cfg_wdata[mrs_pkg::SETP_W-1:0];
                mrs_pkg::CFG_TARGET:  cfg_reg.target  <= cfg_wdata[mrs_pkg::TICK_W-1:0];
                mrs_pkg::CFG_REVERSE: cfg_reg.reverse <= cfg_wdata[0];
                default:              cfg_reg         <= cfg_reg;
            endcase
        end
    end

    // Evaluate the whole event in one pass from the current state
    mrs_core u_core (
        .state        (state_reg),
        .cfg          (cfg_reg),
        .req_type     (req.req_type),
        .sys_running  (req.sys_running),
        .sys_estopped (req.sys_estopped),
        .state_next   (state_next),
        .result       (result)
    );

    // Commit the new state only on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.run_flag       <= 1'b0;
            state_reg.active_timed   <= 1'b0;
            state_reg.active_target  <= '0;
            state_reg.active_reverse <= 1'b0;
            state_reg.pos            <= '0;
            state_reg.level          <= '0;
            state_reg.ticks          <= '0;
            state_reg.duty           <= '0;
            state_reg.dir            <= mrs_pkg::DIR_COAST;
            state_reg.stby           <= 1'b1;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Hold each result until the consumer takes it
    mrs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .can_push  (can_push),
        .res       (res)
    );

endmodule

FILE: src/mrs_checker.sv
// Port-level assertions for the motor run sequencer, bound to the top level.
// Depends on mrs_pkg and the assertion macros header.
`include "motor_run_sequencer_top_defines.svh"

module mrs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [mrs_pkg::POS_W-1:0]    position,
    input logic [mrs_pkg::LEVEL_W-1:0]  drive_level,
    input logic [mrs_pkg::TICK_W-1:0]   elapsed,
    input logic [mrs_pkg::DUTY_W-1:0]   pwm_duty,
    input logic [mrs_pkg::DIR_W-1:0]    bridge_dir,
    input logic                         driver_enable,
    input logic                         running,
    input logic                         accepted,
    input logic                         target_done,
    input logic                         published
);

    logic [$bits(mrs_pkg::result_t)-1:0] payload;

    assign payload = {position, drive_level, elapsed, pwm_duty, bridge_dir,
                      driver_enable, running, accepted, target_done, published};

    `MRS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(payload), "result changed while stalled")
    `MRS_ASSERT_NEXT(a_res_follows, req_valid && req_ready, res_valid, "accepted request gave no result")
    `MRS_ASSERT(a_accept_publish, !res_valid || !accepted || published, "accepted without publish")
    `MRS_ASSERT(a_done_stopped, !res_valid || !target_done || (!running && bridge_dir == mrs_pkg::DIR_COAST), "finished run still driven")
    `MRS_ASSERT(a_idle_quiet, !res_valid || running || (pwm_duty == '0 && bridge_dir == mrs_pkg::DIR_COAST), "bridge driven while stopped")

endmodule

bind motor_run_sequencer_top mrs_checker u_mrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .position      (res.position),
    .drive_level   (res.drive_level),
    .elapsed       (res.elapsed),
    .pwm_duty      (res.pwm_duty),
    .bridge_dir    (res.bridge_dir),
    .driver_enable (res.driver_enable),
    .running       (res.running),
    .accepted      (res.accepted),
    .target_done   (res.target_done),
    .published     (res.published)
);
